[hdl/rpj_pkg.sv]
// Types, constants and register codes shared by the depth reprojection pipeline.
// Used by rpj_ray, rpj_div, depth_pixel_reprojection and rpj_checker.
package rpj_pkg;

   localparam int COORD_BITS = 12;
   localparam int DEPTH_BITS = 16;
   // Quotient bits kept by the dividers: enough to tell any 16-bit bound
   localparam int QUO_BITS   = 17;
   // Scaled depth width: raw depth times a 32-bit Q16.16 factor
   localparam int Z_BITS     = DEPTH_BITS + 32;
   // Signed ray width: two 32 x (COORD_BITS+1) products plus an offset
   localparam int RAY_BITS   = 32 + COORD_BITS + 3;
   localparam int MAG_BITS   = RAY_BITS - 1;
   localparam int NUM_REGS   = 8;
   localparam int IDX_BITS   = 4;

   typedef enum logic [IDX_BITS-1:0] {
      REG_ROW0_A      = 4'd0,
      REG_ROW0_B      = 4'd1,
      REG_ROW1_A      = 4'd2,
      REG_ROW1_B      = 4'd3,
      REG_ROW2_A      = 4'd4,
      REG_ROW2_B      = 4'd5,
      REG_DEPTH_SCALE = 4'd6,
      REG_FRAME_SIZE  = 4'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      DROP_NONE      = 2'd0,
      DROP_SRC_ZERO  = 2'd1,
      DROP_NONPOS    = 2'd2,
      DROP_OUTSIDE   = 2'd3
   } drop_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] src_column;
      logic [COORD_BITS-1:0] src_row;
      logic [DEPTH_BITS-1:0] raw_depth;
      logic                  frame_start;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] dst_column;
      logic [COORD_BITS-1:0] dst_row;
      logic [31:0]           dst_depth;
      logic                  write_enable;
      logic [1:0]            drop_reason;
      logic                  clear_frame;
   } rsp_type;

   // Flags that ride along the pipeline next to the arithmetic
   typedef struct packed {
      logic        frame_start;
      logic        zero_depth;
      logic        nonpos;
      logic        neg_col;
      logic        neg_row;
      logic [31:0] depth;
   } side_type;

endpackage

[hdl/rpj_ray.sv]
// One projected coordinate p = trunc(z * (m0*u + m1*v + m2)) + c, five register stages.
// Depends on rpj_pkg; stage enables come from the top level.
module rpj_ray (
   input  logic                          clock,
   input  logic [4:0]                    en,
   input  logic [rpj_pkg::COORD_BITS-1:0] u,
   input  logic [rpj_pkg::COORD_BITS-1:0] v,
   input  logic [63:0]                   coef_a,
   input  logic [63:0]                   coef_b,
   input  logic [rpj_pkg::Z_BITS-1:0]    z,
   output logic [63:0]                   p_out
);

   localparam int PRW = 32 + rpj_pkg::COORD_BITS + 1;
   localparam int RB  = rpj_pkg::RAY_BITS;
   localparam int MB  = rpj_pkg::MAG_BITS;
   localparam int ZB  = rpj_pkg::Z_BITS;
   localparam int ZL  = ZB / 2;
   localparam int ZH  = ZB - ZL;
   localparam int ML  = MB / 2;
   localparam int MH  = MB - ML;
   localparam int PW  = ZB + MB;
   localparam int SW  = PW - 16;

   logic signed [PRW-1:0] mu_ff, mu_in, mv_ff, mv_in;
   logic signed [RB-1:0]  ray_sum;
   logic [MB-1:0]         mag_ff, mag_in;
   logic                  neg1_ff, neg2_ff, neg3_ff;
   logic [ZL+ML-1:0]      ll_ff, ll_in;
   logic [ZL+MH-1:0]      lh_ff, lh_in;
   logic [ZH+ML-1:0]      hl_ff, hl_in;
   logic [ZH+MH-1:0]      hh_ff, hh_in;
   logic [PW-1:0]         full_sum;
   logic [SW-1:0]         shifted;
   logic [62:0]           pm_ff, pm_in;
   logic [63:0]           pm_ext;
   logic [63:0]           p_ff, p_in;

   // stage 0: coordinate products
   always_comb begin
      mu_in = $signed(coef_a[31:0]) * $signed({1'b0, u});
      mv_in = $signed(coef_a[63:32]) * $signed({1'b0, v});
   end

   // stage 1: ray sum, split into sign and magnitude
   always_comb begin
      ray_sum = RB'(mu_ff) + RB'(mv_ff) + RB'($signed(coef_b[31:0]));
      mag_in  = ray_sum[RB-1] ? MB'(-ray_sum) : MB'(ray_sum);
   end

   // stage 2: partial products of depth and magnitude
   always_comb begin
      ll_in = z[ZL-1:0] * mag_ff[ML-1:0];
      lh_in = z[ZL-1:0] * mag_ff[MB-1:ML];
      hl_in = z[ZB-1:ZL] * mag_ff[ML-1:0];
      hh_in = z[ZB-1:ZL] * mag_ff[MB-1:ML];
   end

   // stage 3: combine, drop 16 fraction bits, cap at 2^62
   always_comb begin
      full_sum = PW'(ll_ff) + (PW'(lh_ff) << ML) + (PW'(hl_ff) << ZL)
               + (PW'(hh_ff) << (ZL + ML));
      shifted  = full_sum[PW-1:16];
      pm_in    = (shifted > (SW'(1) << 62)) ? (63'(1) << 62) : shifted[62:0];
   end

   // stage 4: restore sign and add offset
   always_comb begin
      pm_ext = {1'b0, pm_ff};
      p_in   = (neg3_ff ? -pm_ext : pm_ext) + {{32{coef_b[63]}}, coef_b[63:32]};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mu_ff <= mu_in;
         mv_ff <= mv_in;
      end
      if (en[1]) begin
         mag_ff  <= mag_in;
         neg1_ff <= ray_sum[RB-1];
      end
      if (en[2]) begin
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         hh_ff   <= hh_in;
         neg2_ff <= neg1_ff;
      end
      if (en[3]) begin
         pm_ff   <= pm_in;
         neg3_ff <= neg2_ff;
      end
      if (en[4]) begin
         p_ff <= p_in;
      end
   end

   assign p_out = p_ff;

endmodule

[hdl/rpj_div.sv]
// Pipelined restoring divider giving floor(2*num/den), one quotient bit per stage.
// Depends on rpj_pkg; flags a quotient that does not fit in QUO_BITS.
module rpj_div (
   input  logic                          clock,
   input  logic [rpj_pkg::QUO_BITS:0]    en,
   input  logic [62:0]                   num,
   input  logic [62:0]                   den,
   output logic [rpj_pkg::QUO_BITS-1:0]  quo,
   output logic                          ovf
);

   localparam int QB = rpj_pkg::QUO_BITS;
   localparam int DW = 64 + QB;

   logic [DW-1:0] r_ff   [0:QB-1];
   logic [62:0]   d_ff   [0:QB-1];
   logic [QB-1:0] q_ff   [0:QB];
   logic          ovf_ff [0:QB];
   logic [DW-1:0] r0_in;

   // prep: doubled numerator, range check against den * 2^QB
   assign r0_in = DW'({num, 1'b0});

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0]   <= r0_in;
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= (r0_in >= (DW'(den) << QB));
      end
   end

   // one compare-subtract per stage, MSB first
   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [DW-1:0] trial;
      logic          ge;

      always_comb begin
         trial = DW'(d_ff[k-1]) << (QB - k);
         ge    = (r_ff[k-1] >= trial);
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            q_ff[k]   <= {q_ff[k-1][QB-2:0], ge};
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end

      // carry remainder and divisor to the next step
      if (k < QB) begin : g_carry
         always_ff @(posedge clock) begin
            if (en[k]) begin
               r_ff[k] <= ge ? (r_ff[k-1] - trial) : r_ff[k-1];
               d_ff[k] <= d_ff[k-1];
            end
         end
      end
   end

   assign quo = q_ff[QB];
   assign ovf = ovf_ff[QB];

endmodule

[hdl/depth_pixel_reprojection.sv]
// Throughput: one word per cycle while rsp_stall is low; each pipeline stage
// advances when it is empty or the stage after it advances, so bubbles
// collapse under a response stall. The pipeline depth is set by the two
// 18-stage dividers that form column and row.
// Reset (synchronous): all stage valids clear, CSRs take their defaults.
module depth_pixel_reprojection (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rpj_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rpj_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rpj_pkg::IDX_BITS-1:0]     csr_index,
   input  logic [63:0]                      csr_wdata
);

   localparam int QB   = rpj_pkg::QUO_BITS;
   localparam int CB   = rpj_pkg::COORD_BITS;
   localparam int DIV0 = 5;
   localparam int LAST = DIV0 + QB;
   localparam int NSTG = LAST + 2;

   logic [63:0]              coef_ff [0:5];
   logic [31:0]              scale_ff;
   logic [31:0]              size_ff;
   logic [NSTG-1:0]          v_ff;
   logic [NSTG-1:0]          en;
   rpj_pkg::side_type        side_ff [0:LAST];
   rpj_pkg::side_type        side0_in;
   rpj_pkg::side_type        side5_in;
   logic [rpj_pkg::Z_BITS-1:0] z0_ff, z1_ff, z0_in;
   logic [63:0]              p0, p1, p2;
   logic [62:0]              mag0, mag1;
   logic [QB-1:0]            quo_c, quo_r;
   logic                     ovf_c, ovf_r;
   logic [QB:0]              sum_c, sum_r;
   logic [QB-1:0]            q_c, q_r;
   logic                     outside;
   rpj_pkg::rsp_type         rsp_ff, rsp_in;

   // configuration: always ready, writes beyond the list are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= 64'd65536;
         coef_ff[1] <= 64'd0;
         coef_ff[2] <= 64'd65536 << 32;
         coef_ff[3] <= 64'd0;
         coef_ff[4] <= 64'd0;
         coef_ff[5] <= 64'd65536;
         scale_ff   <= 32'd65536;
         size_ff    <= 32'd31457920;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rpj_pkg::REG_ROW0_A:      coef_ff[0] <= csr_wdata;
            rpj_pkg::REG_ROW0_B:      coef_ff[1] <= csr_wdata;
            rpj_pkg::REG_ROW1_A:      coef_ff[2] <= csr_wdata;
            rpj_pkg::REG_ROW1_B:      coef_ff[3] <= csr_wdata;
            rpj_pkg::REG_ROW2_A:      coef_ff[4] <= csr_wdata;
            rpj_pkg::REG_ROW2_B:      coef_ff[5] <= csr_wdata;
            rpj_pkg::REG_DEPTH_SCALE: scale_ff   <= csr_wdata[31:0];
            rpj_pkg::REG_FRAME_SIZE:  size_ff    <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // stage enables: advance when empty or when the next stage advances
   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // scaled depth, shared by the three ray units
   assign z0_in = req_data.raw_depth * scale_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         z0_ff <= z0_in;
      end
      if (en[1]) begin
         z1_ff <= z0_ff;
      end
   end

   rpj_ray u_ray0 (
      .clock  (clock),
      .en     (en[4:0]),
      .u      (req_data.src_column),
      .v      (req_data.src_row),
      .coef_a (coef_ff[0]),
      .coef_b (coef_ff[1]),
      .z      (z1_ff),
      .p_out  (p0)
   );

   rpj_ray u_ray1 (
      .clock  (clock),
      .en     (en[4:0]),
      .u      (req_data.src_column),
      .v      (req_data.src_row),
      .coef_a (coef_ff[2]),
      .coef_b (coef_ff[3]),
      .z      (z1_ff),
      .p_out  (p1)
   );

   rpj_ray u_ray2 (
      .clock  (clock),
      .en     (en[4:0]),
      .u      (req_data.src_column),
      .v      (req_data.src_row),
      .coef_a (coef_ff[4]),
      .coef_b (coef_ff[5]),
      .z      (z1_ff),
      .p_out  (p2)
   );

   // sideband entry: frame marker and zero-depth flag
   always_comb begin
      side0_in             = '0;
      side0_in.frame_start = req_data.frame_start;
      side0_in.zero_depth  = (req_data.raw_depth == '0) || (scale_ff == 32'd0);
   end

   // sideband: capture flags where they become known, else carry along
   always_comb begin
      side5_in         = side_ff[DIV0-1];
      side5_in.nonpos  = p2[63] || (p2 == 64'd0);
      side5_in.neg_col = p0[63];
      side5_in.neg_row = p1[63];
      side5_in.depth   = (p2[63:32] != 32'd0) ? 32'hFFFF_FFFF : p2[31:0];
      mag0             = p0[63] ? 63'(-p0) : p0[62:0];
      mag1             = p1[63] ? 63'(-p1) : p1[62:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_ff[0] <= side0_in;
      end
      for (int k = 1; k <= LAST; k++) begin
         if (en[k]) begin
            side_ff[k] <= (k == DIV0) ? side5_in : side_ff[k-1];
         end
      end
   end

   rpj_div u_div_col (
      .clock (clock),
      .en    (en[LAST:DIV0]),
      .num   (mag0),
      .den   (p2[62:0]),
      .quo   (quo_c),
      .ovf   (ovf_c)
   );

   rpj_div u_div_row (
      .clock (clock),
      .en    (en[LAST:DIV0]),
      .num   (mag1),
      .den   (p2[62:0]),
      .quo   (quo_r),
      .ovf   (ovf_r)
   );

   // round half away from zero, check frame, pick drop reason
   always_comb begin
      sum_c   = (QB+1)'(quo_c) + (QB+1)'(1);
      sum_r   = (QB+1)'(quo_r) + (QB+1)'(1);
      q_c     = sum_c[QB:1];
      q_r     = sum_r[QB:1];
      outside = ovf_c || ovf_r
             || (side_ff[LAST].neg_col && (q_c != '0))
             || (side_ff[LAST].neg_row && (q_r != '0))
             || (q_c >= QB'(size_ff[15:0])) || (q_r >= QB'(size_ff[31:16]))
             || (q_c[QB-1:CB] != '0) || (q_r[QB-1:CB] != '0);
      rsp_in             = '0;
      rsp_in.clear_frame = side_ff[LAST].frame_start;
      priority if (side_ff[LAST].zero_depth) begin
         rsp_in.drop_reason = rpj_pkg::DROP_SRC_ZERO;
      end else if (side_ff[LAST].nonpos) begin
         rsp_in.drop_reason = rpj_pkg::DROP_NONPOS;
      end else if (outside) begin
         rsp_in.drop_reason = rpj_pkg::DROP_OUTSIDE;
      end else begin
         rsp_in.drop_reason  = rpj_pkg::DROP_NONE;
         rsp_in.write_enable = 1'b1;
         rsp_in.dst_column   = q_c[CB-1:0];
         rsp_in.dst_row      = q_r[CB-1:0];
         rsp_in.dst_depth    = side_ff[LAST].depth;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NSTG-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v_ff[NSTG-1];
   assign rsp_data  = rsp_ff;

endmodule

[hdl/rpj_checker.sv]
// Port-level checks on the response channel of depth_pixel_reprojection.
// Depends on rpj_pkg; attached to the top level by the bind below.
module rpj_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rpj_pkg::rsp_type rsp_data
);

   // hold a stalled response word
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // write flag agrees with drop reason
   a_we_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.write_enable == (rsp_data.drop_reason == rpj_pkg::DROP_NONE)))
      else $error("write_enable disagrees with drop_reason");

   // dropped words carry zero target fields
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.write_enable |->
         rsp_data.dst_column == '0 && rsp_data.dst_row == '0 && rsp_data.dst_depth == '0)
      else $error("dropped word has nonzero target fields");

   // a written pixel has positive depth
   a_depth_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.write_enable |-> rsp_data.dst_depth != '0)
      else $error("written pixel with zero depth");

endmodule

bind depth_pixel_reprojection rpj_checker u_rpj_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/depth_pixel_reprojection_tb.sv]
// Self-checking bench for depth_pixel_reprojection: streams depth pixel words
// through the pipeline under random idling and stalls, checks every response word.
// Depends on rpj_pkg and the depth_pixel_reprojection RTL.
module depth_pixel_reprojection_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_WAIT  = 40;
   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rpj_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rpj_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rpj_pkg::IDX_BITS-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // Local copy of the coefficient and frame registers
   logic [63:0] coef_regs [rpj_pkg::NUM_REGS];

   rpj_pkg::req_type pixel_queue[$];
   rpj_pkg::rsp_type expected_pixels[$];
   int mismatches = 0;
   int req_gap = 0;
   int rsp_hold = 0;
   int quiet_cycles = 0;
   bit quiet = 1'b0;
   bit timed_out = 1'b0;

   depth_pixel_reprojection DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint sx32(logic [31:0] w);
      logic signed [31:0] s;
      s = w;
      return longint'(s);
   endfunction

   // Project one source pixel into the target frame
   function automatic rpj_pkg::rsp_type reproject(rpj_pkg::req_type px);
      rpj_pkg::rsp_type o;
      logic [47:0] z;
      longint p [3];
      longint ray, pm;
      longint unsigned mag, m, d, rem;
      longint unsigned q [2];
      bit neg [2];
      logic [127:0] prod;
      logic [15:0] w, h;
      o = '0;
      o.clear_frame = px.frame_start;
      z = px.raw_depth * coef_regs[rpj_pkg::REG_DEPTH_SCALE][31:0];
      if (z == 0) begin
         o.drop_reason = rpj_pkg::DROP_SRC_ZERO;
         return o;
      end
      for (int i = 0; i < 3; i++) begin
         ray = sx32(coef_regs[2*i][31:0]) * longint'({52'b0, px.src_column})
             + sx32(coef_regs[2*i][63:32]) * longint'({52'b0, px.src_row})
             + sx32(coef_regs[2*i+1][31:0]);
         mag = ray < 0 ? -ray : ray;
         prod = ({80'b0, z} * {64'b0, mag}) >> 16;
         if (prod > (128'd1 << 62)) prod = 128'd1 << 62;
         pm = longint'(prod[63:0]);
         p[i] = (ray < 0 ? -pm : pm) + sx32(coef_regs[2*i+1][63:32]);
      end
      if (p[2] <= 0) begin
         o.drop_reason = rpj_pkg::DROP_NONPOS;
         return o;
      end
      d = p[2];
      for (int i = 0; i < 2; i++) begin
         m = p[i] < 0 ? -p[i] : p[i];
         q[i] = m / d;
         rem = m % d;
         if (rem >= d - rem) q[i]++;
         neg[i] = (p[i] < 0) && (q[i] != 0);
      end
      w = coef_regs[rpj_pkg::REG_FRAME_SIZE][15:0];
      h = coef_regs[rpj_pkg::REG_FRAME_SIZE][31:16];
      if (neg[0] || neg[1] || q[0] >= w || q[1] >= h || q[0] > 4095 || q[1] > 4095) begin
         o.drop_reason = rpj_pkg::DROP_OUTSIDE;
         return o;
      end
      o.dst_column = q[0][11:0];
      o.dst_row = q[1][11:0];
      o.dst_depth = (p[2] > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : p[2][31:0];
      o.write_enable = 1'b1;
      o.drop_reason = rpj_pkg::DROP_NONE;
      return o;
   endfunction

   // Request driver: hold a stalled word, otherwise advance or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_pixels.push_back(reproject(req_data));
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
               req_data <= pixel_queue.pop_front();
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare against the oldest prediction, stall in bursts
   always @(posedge clock) begin
      rpj_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", rsp_data);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.dst_column !== want.dst_column || rsp_data.dst_row !== want.dst_row ||
                rsp_data.dst_depth !== want.dst_depth ||
                rsp_data.write_enable !== want.write_enable ||
                rsp_data.drop_reason !== want.drop_reason ||
                rsp_data.clear_frame !== want.clear_frame) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp col %0d row %0d depth %h we %b drop %0d clr %b",
                     want.dst_column, want.dst_row, want.dst_depth, want.write_enable,
                     want.drop_reason, want.clear_frame,
                     " / act col %0d row %0d depth %h we %b drop %0d clr %b",
                     rsp_data.dst_column, rsp_data.dst_row,
                     rsp_data.dst_depth, rsp_data.write_enable, rsp_data.drop_reason,
                     rsp_data.clear_frame);
            end
         end
      end
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 9) == 0) rsp_hold <= $urandom_range(1, 7);
      end
   end

   // Watchdog: count cycles with work outstanding and no word accepted
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready) ||
          (pixel_queue.size() == 0 && expected_pixels.size() == 0 && !req_valid)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [rpj_pkg::IDX_BITS-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < rpj_pkg::NUM_REGS)
         coef_regs[idx] = (idx >= rpj_pkg::REG_DEPTH_SCALE) ? {32'b0, val[31:0]} : val;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pixel_queue.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic load_regs(input logic [63:0] r0, r1, r2, r3, r4, r5, r6, r7);
      wait_idle();
      csr_write(rpj_pkg::REG_ROW0_A, r0);
      csr_write(rpj_pkg::REG_ROW0_B, r1);
      csr_write(rpj_pkg::REG_ROW1_A, r2);
      csr_write(rpj_pkg::REG_ROW1_B, r3);
      csr_write(rpj_pkg::REG_ROW2_A, r4);
      csr_write(rpj_pkg::REG_ROW2_B, r5);
      csr_write(rpj_pkg::REG_DEPTH_SCALE, r6);
      csr_write(rpj_pkg::REG_FRAME_SIZE, r7);
      // an index past the register file must be ignored
      csr_write(4'($urandom_range(rpj_pkg::NUM_REGS, 15)), {$urandom, $urandom});
   endtask

   function automatic rpj_pkg::req_type pixel(int u, int v, int raw, bit fs);
      rpj_pkg::req_type p;
      p.src_column = 12'(u);
      p.src_row = 12'(v);
      p.raw_depth = 16'(raw);
      p.frame_start = fs;
      return p;
   endfunction

   function automatic rpj_pkg::req_type rand_pixel();
      rpj_pkg::req_type p;
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         p.src_column = 12'($urandom_range(0, 700));
         p.src_row = 12'($urandom_range(0, 520));
      end else begin
         p.src_column = 12'($urandom);
         p.src_row = 12'($urandom);
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) p.raw_depth = '0;
      else if (sel < 6) p.raw_depth = 16'($urandom_range(1, 2000));
      else p.raw_depth = 16'($urandom);
      p.frame_start = ($urandom_range(0, 49) == 0);
      return p;
   endfunction

   function automatic logic [31:0] near(int base, int spread);
      return 32'(base + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   initial begin
      logic [31:0] fs;
      coef_regs[rpj_pkg::REG_ROW0_A] = 64'd65536;
      coef_regs[rpj_pkg::REG_ROW0_B] = 64'd0;
      coef_regs[rpj_pkg::REG_ROW1_A] = 64'd65536 << 32;
      coef_regs[rpj_pkg::REG_ROW1_B] = 64'd0;
      coef_regs[rpj_pkg::REG_ROW2_A] = 64'd0;
      coef_regs[rpj_pkg::REG_ROW2_B] = 64'd65536;
      coef_regs[rpj_pkg::REG_DEPTH_SCALE] = 64'd65536;
      coef_regs[rpj_pkg::REG_FRAME_SIZE] = 64'd31457920;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default identity mapping: edges of frame, zero depth, field extremes
      pixel_queue.push_back(pixel(0, 0, 0, 1));
      pixel_queue.push_back(pixel(4095, 4095, 65535, 0));
      pixel_queue.push_back(pixel(0, 0, 1, 0));
      pixel_queue.push_back(pixel(639, 479, 100, 1));
      pixel_queue.push_back(pixel(640, 10, 5, 0));
      pixel_queue.push_back(pixel(10, 480, 5, 0));
      pixel_queue.push_back(pixel(321, 123, 65535, 0));
      pixel_queue.push_back(pixel(2730, 1365, 43690, 1));
      pixel_queue.push_back(pixel(1365, 2730, 21845, 0));

      // Half-pixel rounding and negative coordinates, including ones rounding to zero
      load_regs(64'h0000_0000_0000_8000, 64'h0,
                64'hFFFF_C000_0000_0000, 64'h0, 64'h0, 64'h0000_0000_0001_0000,
                64'h0001_0000, 64'h01E0_0280);
      for (int u = 0; u < 6; u++) pixel_queue.push_back(pixel(u, u, 3, 0));

      // Negative target depth
      load_regs(64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
                64'h0, 64'h0000_0000_FFFF_0000, 64'h0001_0000, 64'h01E0_0280);
      pixel_queue.push_back(pixel(5, 5, 7, 0));
      pixel_queue.push_back(pixel(0, 0, 65535, 1));

      // Extremes: all-zero registers, then all-ones registers
      load_regs(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
      pixel_queue.push_back(pixel(100, 100, 500, 0));
      pixel_queue.push_back(pixel(4095, 0, 65535, 1));
      load_regs('1, '1, '1, '1, '1, '1, '1, '1);
      pixel_queue.push_back(pixel(0, 0, 65535, 0));
      pixel_queue.push_back(pixel(4095, 4095, 65535, 1));
      pixel_queue.push_back(pixel(7, 9, 1, 0));

      // Random phases, mostly near-identity mappings with varied frames
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 7) quiet = 1'b1;
         fs = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
              : {16'($urandom_range(1, 600)), 16'($urandom_range(1, 800))};
         if (ph == 3) begin
            load_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
         end else begin
            load_regs({near(0, 8192), near(65536, 16384)},
                      {near(0, 1 << 24), near(0, 50 << 16)},
                      {near(65536, 16384), near(0, 8192)},
                      {near(0, 1 << 24), near(0, 50 << 16)},
                      {near(0, 64), near(0, 64)},
                      {near(0, 1 << 20), near(65536, 8192)},
                      (ph == 5) ? 64'hFFFF_FFFF : 64'($urandom_range(32'h4000, 32'h40000)),
                      {32'b0, fs});
         end
         for (int i = 0; i < 240; i++) pixel_queue.push_back(rand_pixel());
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
